// ----- sv/plc_pkg.sv -----
`timescale 1ns / 1ps
package plc_pkg;

  localparam int unsigned NumElems = 16;
  localparam int unsigned ElemW = 16;
  localparam int unsigned SumW = 27;
  localparam int unsigned InlW = 16;
  localparam int unsigned InlSumW = 26;
  localparam int unsigned CountW = 11;
  localparam int unsigned DistW = 37;
  localparam int unsigned MaxMembers = 1024;
  localparam logic [31:0] ThresholdReset = 32'd8220835;

  typedef enum logic [0:0] {
    KIND_ADD = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  typedef struct packed {
    logic [15:0] inlier_frac;
    logic [63:0] pose_row3;
    logic [63:0] pose_row2;
    logic [63:0] pose_row1;
    logic [63:0] pose_row0;
    logic kind;
  } in_item_t;

  typedef struct packed {
    logic [15:0] mean_inlier;
    logic [63:0] mean_row3;
    logic [63:0] mean_row2;
    logic [63:0] mean_row1;
    logic [63:0] mean_row0;
    logic [10:0] member_count;
    logic dropped;
    logic created_new;
    logic [3:0] cluster_idx;
  } out_item_t;

  // Restoring divider request grouping: start strobe and divisor.
  typedef struct packed {
    logic start;
    logic [CountW-1:0] divisor;
  } div_ctrl_t;

endpackage

// ----- sv/plc_dist_lane.sv -----
`timescale 1ns / 1ps
module plc_dist_lane (
  input  logic signed [plc_pkg::ElemW-1:0] pose_i,
  input  logic signed [plc_pkg::ElemW-1:0] mean_i,
  output logic [32:0] sq_o
);
  import plc_pkg::*;

  logic signed [ElemW:0] diff;
  logic signed [2*ElemW+1:0] prod;

  assign diff = {pose_i[ElemW-1], pose_i} - {mean_i[ElemW-1], mean_i};
  assign prod = diff * diff;
  assign sq_o = prod[32:0];

endmodule

// ----- sv/plc_div_lane.sv -----
`timescale 1ns / 1ps
module plc_div_lane #(
  parameter int unsigned NumW = 27
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  plc_pkg::div_ctrl_t ctrl_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic is_signed_i,
  output logic [NumW-1:0] quot_o
);
  import plc_pkg::*;

  // One quotient bit per cycle on the magnitude; sign fixed at the end.
  logic [NumW-1:0] mag_q, mag_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [CountW:0] rem_q, rem_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic neg_q, neg_d;
  logic [CountW:0] trial;
  logic [CountW+1:0] diff;

  always_comb begin
    mag_d = mag_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    trial = '0;
    diff = '0;
    if (ctrl_i.start) begin
      neg_d = is_signed_i & dividend_i[NumW-1];
      mag_d = neg_d ? (~dividend_i + 1'b1) : dividend_i;
      quo_d = '0;
      rem_d = '0;
      dvs_d = ctrl_i.divisor;
    end else begin
      trial = {rem_q[CountW-1:0], mag_q[NumW-1]};
      diff = {1'b0, trial} - {2'b00, dvs_q};
      mag_d = {mag_q[NumW-2:0], 1'b0};
      if (!diff[CountW+1]) begin
        rem_d = diff[CountW:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else begin
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ----- sv/pose_leader_clustering_unit.sv -----
`timescale 1ns / 1ps
// Leader clustering of 4x4 poses.
// Input channel in_valid_i/in_ready_o carries one item: a clear command or a
// pose with its inlier fraction. Output channel out_valid_o/out_ready_i
// returns one result item per input item. The config channel
// cfg_valid_i/cfg_ready_o writes the squared distance threshold; it is
// always ready and must be used only while the block is idle.
// An add item walks the open cluster means one per cycle, sixteen distance
// lanes working in parallel with an adder tree merging their squares. A
// matching or new cluster then has its seventeen sums divided by the count
// in parallel divider lanes, one quotient bit per cycle, and the quotients
// are then captured in the output register.
// A clear result is valid in the cycle after its item is accepted. One item
// is in work at a time. The result sits in an output register; a stalled
// receiver holds it and the next item is accepted the cycle after the
// result is taken.
// Reset empties the cluster table and loads the default threshold. Stored
// means and sums are not cleared; they are only read for open clusters.
module pose_leader_clustering_unit #(
  parameter int unsigned MAX_CLUSTERS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  plc_pkg::in_item_t in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output plc_pkg::out_item_t out_item_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import plc_pkg::*;

  localparam int unsigned IdxW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned UsedW = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned DivSteps = SumW;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] thr_q;
  logic [UsedW-1:0] used_q, used_d;
  logic [UsedW-1:0] scan_q, scan_d;
  logic [IdxW-1:0] hit_q, hit_d;
  logic found_q, found_d;
  logic created_q, created_d;
  logic [4:0] step_q, step_d;
  in_item_t item_q;
  out_item_t res_q, res_d;
  logic [CountW-1:0] cnt_q [MAX_CLUSTERS];
  logic [CountW-1:0] newcnt_q, newcnt_d;

  // Cluster storage memories, one row per cluster.
  logic [NumElems*ElemW-1:0] mean_mem [MAX_CLUSTERS];
  logic [NumElems*SumW-1:0] sum_mem [MAX_CLUSTERS];
  logic [InlSumW-1:0] isum_mem [MAX_CLUSTERS];
  logic [NumElems*ElemW-1:0] mean_rd_q;
  logic [NumElems*SumW-1:0] sum_rd_q;
  logic [InlSumW-1:0] isum_rd_q;
  logic [NumElems*SumW-1:0] newsum_q;
  logic [InlSumW-1:0] newisum_q;

  logic [IdxW-1:0] rd_addr;
  logic rd_valid_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [32:0] sq [NumElems];
  logic [DistW-1:0] half_q [2];
  logic dist_valid_q;
  logic [IdxW-1:0] dist_idx_q;
  logic [DistW-1:0] dist_sum;
  logic [NumElems*ElemW-1:0] pose_flat;
  logic [NumElems*ElemW-1:0] quot_elems;
  logic [SumW-1:0] quot_inl;
  div_ctrl_t div_ctrl;
  logic mem_we, mean_we;

  assign pose_flat = {item_q.pose_row3, item_q.pose_row2, item_q.pose_row1,
                      item_q.pose_row0};
  assign rd_addr = scan_q[IdxW-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o = res_q;

  // Distance lanes and a two-level merge; the first level is registered.
  for (genvar e = 0; e < NumElems; e++) begin : g_dist
    plc_dist_lane u_lane (
      .pose_i(pose_flat[e*ElemW +: ElemW]),
      .mean_i(mean_rd_q[e*ElemW +: ElemW]),
      .sq_o  (sq[e])
    );
  end

  always_comb begin
    dist_sum = DistW'(half_q[0]) + DistW'(half_q[1]);
  end

  // Divider lanes.
  assign div_ctrl.start = (state_q == ST_UPDATE);
  assign div_ctrl.divisor = newcnt_q;

  for (genvar e = 0; e < NumElems; e++) begin : g_div
    logic [SumW-1:0] q;
    plc_div_lane #(.NumW(SumW)) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (div_ctrl),
      .dividend_i (newsum_q[e*SumW +: SumW]),
      .is_signed_i(1'b1),
      .quot_o     (q)
    );
    assign quot_elems[e*ElemW +: ElemW] = q[ElemW-1:0];
  end

  // Same width as the element lanes so that all quotients finish together.
  plc_div_lane #(.NumW(SumW)) u_div_inl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (SumW'(newisum_q)),
    .is_signed_i(1'b0),
    .quot_o     (quot_inl)
  );

  always_comb begin
    state_d = state_q;
    used_d = used_q;
    scan_d = scan_q;
    hit_d = hit_q;
    found_d = found_q;
    created_d = created_q;
    step_d = step_q;
    res_d = res_q;
    newcnt_d = newcnt_q;
    mem_we = 1'b0;
    mean_we = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          scan_d = '0;
          found_d = 1'b0;
          if (in_item_i.kind == KIND_CLEAR) begin
            used_d = '0;
            res_d = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Addresses issue one a cycle; each distance returns through the mean read register and the half-sum registers.
        if (scan_q < used_q) begin
          scan_d = scan_q + 1'b1;
        end
        if (dist_valid_q && !found_q && dist_sum < DistW'(thr_q)) begin
          found_d = 1'b1;
          hit_d = dist_idx_q;
        end
        if (found_d || (scan_q >= used_q && !rd_valid_q && !dist_valid_q
                        && !step_q[0])) begin
          state_d = ST_CHECK;
        end
        step_d = {4'd0, rd_valid_q};
      end
      ST_CHECK: begin
        res_d = '0;
        if (found_q) begin
          if (cnt_q[hit_q] >= CountW'(MaxMembers)) begin
            res_d.dropped = 1'b1;
            state_d = ST_OUT;
          end else begin
            newcnt_d = cnt_q[hit_q] + 1'b1;
            created_d = 1'b0;
            state_d = ST_UPDATE;
          end
        end else if (used_q >= UsedW'(MAX_CLUSTERS)) begin
          res_d.dropped = 1'b1;
          state_d = ST_OUT;
        end else begin
          hit_d = used_q[IdxW-1:0];
          newcnt_d = CountW'(1);
          created_d = 1'b1;
          used_d = used_q + 1'b1;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
        step_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == 5'(DivSteps)) begin
          mean_we = 1'b1;
          res_d.cluster_idx = 4'(hit_q);
          res_d.created_new = created_q;
          res_d.dropped = 1'b0;
          res_d.member_count = newcnt_q;
          {res_d.mean_row3, res_d.mean_row2, res_d.mean_row1, res_d.mean_row0}
            = quot_elems;
          res_d.mean_inlier = quot_inl[InlW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // New sums are formed the cycle before the update from the read row.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_item_i;
    end
    mean_rd_q <= mean_mem[rd_addr];
    half_q[0] <= DistW'(sq[0]) + DistW'(sq[1]) + DistW'(sq[2]) + DistW'(sq[3])
               + DistW'(sq[4]) + DistW'(sq[5]) + DistW'(sq[6]) + DistW'(sq[7]);
    half_q[1] <= DistW'(sq[8]) + DistW'(sq[9]) + DistW'(sq[10]) + DistW'(sq[11])
               + DistW'(sq[12]) + DistW'(sq[13]) + DistW'(sq[14]) + DistW'(sq[15]);
    sum_rd_q <= sum_mem[hit_d];
    isum_rd_q <= isum_mem[hit_d];
    if (state_q == ST_CHECK) begin
      for (int e = 0; e < NumElems; e++) begin
        newsum_q[e*SumW +: SumW] <= created_d
          ? SumW'($signed(pose_flat[e*ElemW +: ElemW]))
          : sum_rd_q[e*SumW +: SumW] + SumW'($signed(pose_flat[e*ElemW +: ElemW]));
      end
      newisum_q <= created_d ? InlSumW'(item_q.inlier_frac)
                             : isum_rd_q + InlSumW'(item_q.inlier_frac);
    end
    if (mem_we) begin
      sum_mem[hit_q] <= newsum_q;
      isum_mem[hit_q] <= newisum_q;
    end
    if (mean_we) begin
      mean_mem[hit_q] <= quot_elems;
    end
    res_q <= res_d;
    newcnt_q <= newcnt_d;
    hit_q <= hit_d;
    created_q <= created_d;
    dist_idx_q <= rd_idx_q;
    rd_idx_q <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q <= ThresholdReset;
      used_q <= '0;
      scan_q <= '0;
      found_q <= 1'b0;
      step_q <= '0;
      rd_valid_q <= 1'b0;
      dist_valid_q <= 1'b0;
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      scan_q <= scan_d;
      found_q <= found_d;
      step_q <= step_d;
      rd_valid_q <= (state_q == ST_SCAN) && (scan_q < used_q) && !found_d;
      dist_valid_q <= rd_valid_q && (state_q == ST_SCAN);
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (state_q == ST_IDLE && in_valid_i && in_item_i.kind == KIND_CLEAR) begin
        for (int k = 0; k < MAX_CLUSTERS; k++) begin
          cnt_q[k] <= '0;
        end
      end else if (mem_we) begin
        cnt_q[hit_q] <= newcnt_q;
      end
    end
  end

endmodule

// ----- sv/plc_checker.sv -----
`timescale 1ns / 1ps
module plc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input plc_pkg::out_item_t out_item_o
);
  import plc_pkg::*;

  // A dropped result carries no count; a new cluster's result has one member.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.dropped |-> out_item_o.member_count == '0)
    else $error("dropped result carries a count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.created_new |-> out_item_o.member_count == 11'd1)
    else $error("new cluster count is not one");

  // One item in work at a time: no new acceptance while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind pose_leader_clustering_unit plc_checker u_plc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
